/* rtl/core/hba_pkg.sv */
`default_nettype none
package hba_pkg;
  localparam int BINS_DEFAULT = 64;
  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_BOUND = 2'd3;
  localparam logic [1:0] MODE_UNIFORM = 2'd0;
  localparam logic [1:0] MODE_SHIFT = 2'd1;
  localparam logic [1:0] MODE_BASE = 2'd2;
  localparam logic [1:0] MODE_TABLE = 2'd3;
  localparam logic [1:0] REGION_BIN = 2'd0;
  localparam logic [1:0] REGION_UNDER = 2'd1;
  localparam logic [1:0] REGION_OVER = 2'd2;
  localparam logic [1:0] REGION_NONE = 2'd3;
  localparam logic [2:0] CFG_MODE = 3'd0;
  localparam logic [2:0] CFG_BINS = 3'd1;
  localparam logic [2:0] CFG_START = 3'd2;
  localparam logic [2:0] CFG_WIDTH = 3'd3;
  localparam logic [2:0] CFG_SHIFT = 3'd4;
  localparam logic [2:0] CFG_BASE = 3'd5;
endpackage
`default_nettype wire

/* rtl/core/histogram_bin_accumulator_unit.sv */
`default_nettype none
// Histogram accumulator. Each request on the slave stream gives one result on the master
// stream. Every request runs through a small sequencer around one shared 64-bit
// restoring divider and compare unit, one bit per cycle. A uniform-mode add runs a 32-step
// division plus memory access and a multiply step; a power-of-two add shifts once per binning
// step and an any-base add runs a full division per binning step, with at most bins_in_use
// steps (capped at BINS, and at least one); a table add scans the bound table one bound at a
// time; clear also sweeps every bin address. After reset the block clears its bin memory and
// bound table before the first request is taken.
module histogram_bin_accumulator_unit
  import hba_pkg::*;
#(
  parameter int BINS = BINS_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // req_type, sample_value, sample_weight, bin_select
  input  wire logic [71:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // region, bin_index, bin_count, in_range_sum, underflow_count, underflow_sum,
  // overflow_count, overflow_sum, grand_sum, grand_count
  output logic [519:0]      m_tdata
);
  localparam int AW = $clog2(BINS);
  localparam int NW = $clog2(BINS + 1);

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_DIV = 4'd2;
  localparam logic [3:0] ST_STEP = 4'd3;
  localparam logic [3:0] ST_TBL = 4'd4;
  localparam logic [3:0] ST_TBLW = 4'd5;
  localparam logic [3:0] ST_MUL = 4'd6;
  localparam logic [3:0] ST_RD = 4'd7;
  localparam logic [3:0] ST_RDW = 4'd8;
  localparam logic [3:0] ST_UPD = 4'd9;
  localparam logic [3:0] ST_CLR = 4'd10;
  localparam logic [3:0] ST_OUT = 4'd11;
  localparam logic [3:0] ST_MUL2 = 4'd12;
  localparam logic [3:0] ST_RDA = 4'd13;

  logic [1:0] bin_mode;
  logic [6:0] bins_in_use;
  logic [31:0] bin_origin, bin_width, growth_base;
  logic [4:0] shift_bits;

  logic [63:0] bin_mem [BINS];
  logic [31:0] bound_mem [BINS];
  logic [63:0] mem_q;
  logic [31:0] bound_q;
  logic [AW-1:0] mem_addr, bound_addr;

  logic [3:0] state;
  logic [1:0] req;
  logic [31:0] val, wgt;
  logic [5:0] sel;
  logic [1:0] region;
  logic [NW-1:0] n_eff, steps;
  logic [63:0] x, thr, quo, rem, dvs;
  logic [6:0] cnt;
  logic [63:0] prod;
  logic [63:0] in_range_total, under_count, under_total, over_count, over_total;
  logic [63:0] all_total, all_count, bcnt;
  logic [5:0] bidx;
  logic [AW-1:0] clr_addr;

  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  logic [63:0] div_base;

  always_comb begin
    if (bins_in_use == 7'd0) n_eff = NW'(1);
    else if ({25'd0, bins_in_use} > 32'(BINS)) n_eff = NW'(BINS);
    else n_eff = NW'(bins_in_use);
  end
  assign div_base = (growth_base < 32'd2) ? 64'd2 : {32'd0, growth_base};
  assign rem_sh = {rem, quo[63]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata = {all_count, all_total, over_total, over_count, under_total,
                    under_count, in_range_total, bcnt, bidx, region};

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_mode <= MODE_UNIFORM;
      bins_in_use <= 7'd64;
      bin_origin <= 32'd0;
      bin_width <= 32'd1;
      shift_bits <= 5'd1;
      growth_base <= 32'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: bin_mode <= cfg_data[1:0];
        CFG_BINS: bins_in_use <= cfg_data[6:0];
        CFG_START: bin_origin <= cfg_data;
        CFG_WIDTH: bin_width <= cfg_data;
        CFG_SHIFT: shift_bits <= cfg_data[4:0];
        CFG_BASE: growth_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= bin_mem[mem_addr];
    bound_q <= bound_mem[bound_addr];
    if (state == ST_INIT || state == ST_CLR) bin_mem[clr_addr] <= 64'd0;
    else if (state == ST_UPD) bin_mem[mem_addr] <= bcnt;
    if (state == ST_INIT) bound_mem[clr_addr] <= 32'd0;
    else if (state == ST_IDLE && s_tvalid && s_tdata[1:0] == REQ_BOUND
             && {26'd0, s_tdata[71:66]} < 32'(BINS))
      bound_mem[AW'(s_tdata[71:66])] <= s_tdata[33:2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      clr_addr <= '0;
      in_range_total <= '0; under_count <= '0; under_total <= '0;
      over_count <= '0; over_total <= '0; all_total <= '0; all_count <= '0;
    end else begin
      case (state)
        ST_INIT, ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == 32'(BINS - 1)) begin
            clr_addr <= '0;
            state <= (state == ST_INIT) ? ST_IDLE : ST_OUT;
          end
        end
        ST_IDLE: if (s_tvalid) begin
          req <= s_tdata[1:0];
          val <= s_tdata[33:2];
          wgt <= s_tdata[65:34];
          sel <= s_tdata[71:66];
          region <= REGION_NONE;
          bidx <= 6'd0;
          bcnt <= 64'd0;
          steps <= '0;
          bound_addr <= '0;
          case (s_tdata[1:0])
            REQ_ADD: begin
              x <= {32'd0, s_tdata[33:2]};
              if (bin_mode == MODE_TABLE) state <= ST_TBLW;
              else if (s_tdata[33:2] < bin_origin) begin
                region <= REGION_UNDER;
                state <= ST_MUL;
              end else if (bin_mode == MODE_UNIFORM) begin
                quo <= {s_tdata[33:2] - bin_origin, 32'd0};
                rem <= '0;
                dvs <= {32'd0, (bin_width == 32'd0) ? 32'd1 : bin_width};
                cnt <= 7'd32;
                state <= ST_DIV;
              end else begin
                if (bin_mode == MODE_SHIFT)
                  thr <= {32'd0, bin_origin} << shift_bits;
                else
                  thr <= bin_origin * div_base;
                state <= ST_STEP;
              end
            end
            REQ_READ: begin
              bidx <= s_tdata[71:66];
              mem_addr <= AW'(s_tdata[71:66]);
              state <= ST_RDA;
            end
            REQ_CLEAR: begin
              in_range_total <= '0; under_count <= '0; under_total <= '0;
              over_count <= '0; over_total <= '0; all_total <= '0; all_count <= '0;
              state <= ST_CLR;
            end
            default: state <= ST_OUT;
          endcase
        end
        ST_DIV: begin
          if (!rem_sub[64]) begin
            rem <= rem_sub[63:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) state <= (bin_mode == MODE_UNIFORM) ? ST_MUL2 : ST_STEP;
          if (cnt == 7'd1 && bin_mode != MODE_UNIFORM)
            x <= rem_sub[64] ? {quo[62:0], 1'b0} : {quo[62:0], 1'b1};
        end
        ST_MUL2: begin
          if (quo >= 64'(n_eff)) region <= REGION_OVER;
          else begin
            region <= REGION_BIN;
            bidx <= 6'(quo);
          end
          state <= ST_MUL;
        end
        ST_STEP: begin
          if (x < thr) begin
            region <= REGION_BIN;
            bidx <= 6'(steps);
            state <= ST_MUL;
          end else if (steps + 1'b1 >= n_eff) begin
            region <= REGION_OVER;
            state <= ST_MUL;
          end else begin
            steps <= steps + 1'b1;
            if (bin_mode == MODE_SHIFT) x <= x >> shift_bits;
            else begin
              quo <= {x[31:0], 32'd0}; rem <= '0; dvs <= div_base; cnt <= 7'd32;
              state <= ST_DIV;
            end
          end
        end
        ST_TBLW: state <= ST_TBL;
        ST_TBL: begin
          if (steps == '0) begin
            if (val < bound_q) begin
              region <= REGION_UNDER;
              state <= ST_MUL;
            end else if (n_eff == NW'(1)) begin
              region <= REGION_BIN;
              state <= ST_MUL;
            end else begin
              steps <= NW'(1);
              bound_addr <= AW'(1);
              state <= ST_TBLW;
            end
          end else if (val < bound_q) begin
            region <= REGION_BIN;
            bidx <= 6'(steps - 1'b1);
            state <= ST_MUL;
          end else if (steps + 1'b1 >= n_eff) begin
            region <= REGION_BIN;
            bidx <= 6'(steps);
            state <= ST_MUL;
          end else begin
            steps <= steps + 1'b1;
            bound_addr <= AW'(steps + 1'b1);
            state <= ST_TBLW;
          end
        end
        ST_MUL: begin
          prod <= val * wgt;
          mem_addr <= AW'(bidx);
          state <= ST_RD;
        end
        ST_RD: begin
          all_total <= all_total + prod;
          all_count <= all_count + {32'd0, wgt};
          case (region)
            REGION_UNDER: begin
              under_count <= under_count + {32'd0, wgt};
              under_total <= under_total + prod;
              state <= ST_OUT;
            end
            REGION_OVER: begin
              over_count <= over_count + {32'd0, wgt};
              over_total <= over_total + prod;
              state <= ST_OUT;
            end
            default: begin
              in_range_total <= in_range_total + prod;
              state <= ST_RDW;
            end
          endcase
        end
        ST_RDA: state <= ST_RDW;
        ST_RDW: begin
          if (req == REQ_READ) begin
            bcnt <= ({26'd0, sel} < 32'(BINS)) ? mem_q : 64'd0;
            state <= ST_OUT;
          end else begin
            bcnt <= mem_q + {32'd0, wgt};
            state <= ST_UPD;
          end
        end
        ST_UPD: state <= ST_OUT;
        ST_OUT: if (m_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_region: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == REGION_UNDER || m_tdata[1:0] == REGION_OVER)
    |-> m_tdata[71:2] == 70'd0)
    else $error("bin fields nonzero outside bins");
endmodule
`default_nettype wire
